FILE: hw/rtl/hsvc_pkg.sv
// Shared types, constants and helper functions for the HSV to RGB converter.
// Used by hsvc_frac, hsvc_scale and hsv_to_rgb_converter_top; no dependencies.
package hsvc_pkg;

  localparam int unsigned CHAN_W       = 16;
  localparam int unsigned SECTOR_W     = 3;
  localparam int unsigned SCALED_W     = CHAN_W + SECTOR_W;
  localparam int unsigned PROD_W       = 2 * CHAN_W;
  localparam int unsigned SECTOR_COUNT = 6;
  localparam int unsigned CFG_IDX_W    = 2;

  localparam logic [CHAN_W-1:0] UNIT_ONE  = 16'hFFFF;
  localparam logic [CHAN_W:0]   UNIT_SPAN = 17'h10000;

  localparam logic [CFG_IDX_W-1:0] REG_SATURATION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = 2'd1;

  localparam logic [CHAN_W-1:0] SATURATION_RESET = 16'hFFFF;
  localparam logic [CHAN_W-1:0] BRIGHTNESS_RESET = 16'h7FFF;

  localparam logic [SECTOR_W-1:0] SECT_RED_YELLOW    = 3'd0;
  localparam logic [SECTOR_W-1:0] SECT_YELLOW_GREEN  = 3'd1;
  localparam logic [SECTOR_W-1:0] SECT_GREEN_CYAN    = 3'd2;
  localparam logic [SECTOR_W-1:0] SECT_CYAN_BLUE     = 3'd3;
  localparam logic [SECTOR_W-1:0] SECT_BLUE_MAGENTA  = 3'd4;
  localparam logic [SECTOR_W-1:0] SECT_LAST          = 3'd5;

  typedef struct packed {
    logic                valid;
    logic [SECTOR_W-1:0] sector;
  } hsvc_tag_t;

  // Exact floor(x / 65535) for any x below 65535 * 65536, so for every product of two channel values.
  function automatic logic [CHAN_W-1:0] unit_div(input logic [PROD_W-1:0] x);
    logic [PROD_W:0] sum;
    sum = {1'b0, x} + {{(CHAN_W + 1){1'b0}}, x[PROD_W-1:CHAN_W]} + {{PROD_W{1'b0}}, 1'b1};
    return sum[PROD_W-1:CHAN_W];
  endfunction

endpackage

FILE: hw/rtl/hsvc_frac.sv
// Front pipeline stages: hue times six into sector and fraction, then the
// saturation-weighted fractions f*s and (1-f)*s. Depends on hsvc_pkg.
module hsvc_frac (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [hsvc_pkg::CHAN_W-1:0]  hue_i,
  input  logic [hsvc_pkg::CHAN_W-1:0]  sat_i,
  output hsvc_pkg::hsvc_tag_t          tag_o,
  output logic [hsvc_pkg::CHAN_W-1:0]  fs_o,
  output logic [hsvc_pkg::CHAN_W-1:0]  gs_o
);
  import hsvc_pkg::*;

  logic [SCALED_W-1:0] scaled;
  logic                valid1_r;
  logic [SECTOR_W-1:0] sector1_r;
  logic [CHAN_W-1:0]   frac1_r;
  logic [PROD_W-1:0]   fs_prod;
  logic [CHAN_W:0]     comp_f;
  logic [PROD_W-1:0]   gs_prod;
  hsvc_tag_t           tag2_r;
  logic [CHAN_W-1:0]   fs2_r;
  logic [CHAN_W-1:0]   gs2_r;

  assign scaled  = {{SECTOR_W{1'b0}}, hue_i} * SCALED_W'(SECTOR_COUNT);
  assign fs_prod = {{CHAN_W{1'b0}}, frac1_r} * {{CHAN_W{1'b0}}, sat_i};
  assign comp_f  = UNIT_SPAN - {1'b0, frac1_r};
  assign gs_prod = {{(CHAN_W - 1){1'b0}}, comp_f} * {{CHAN_W{1'b0}}, sat_i};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid1_r     <= 1'b0;
      tag2_r.valid <= 1'b0;
    end else begin
      valid1_r     <= in_valid;
      tag2_r.valid <= valid1_r;
    end
    sector1_r     <= scaled[SCALED_W-1:CHAN_W];
    frac1_r       <= scaled[CHAN_W-1:0];
    tag2_r.sector <= sector1_r;
    fs2_r         <= fs_prod[PROD_W-1:CHAN_W];
    gs2_r         <= gs_prod[PROD_W-1:CHAN_W];
  end

  assign tag_o = tag2_r;
  assign fs_o  = fs2_r;
  assign gs_o  = gs2_r;

`ifndef SYNTHESIS
  a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
    valid1_r |-> (sector1_r <= SECT_LAST))
    else $error("hue sector out of range");
`endif

endmodule

FILE: hw/rtl/hsvc_scale.sv
// Back pipeline stages: value products for p, q and t, then the exact
// division by full scale. Depends on hsvc_pkg.
module hsvc_scale (
  input  logic                         clk,
  input  logic                         rst_n,
  input  hsvc_pkg::hsvc_tag_t          tag_i,
  input  logic [hsvc_pkg::CHAN_W-1:0]  fs_i,
  input  logic [hsvc_pkg::CHAN_W-1:0]  gs_i,
  input  logic [hsvc_pkg::CHAN_W-1:0]  sat_i,
  input  logic [hsvc_pkg::CHAN_W-1:0]  bri_i,
  output hsvc_pkg::hsvc_tag_t          tag_o,
  output logic [hsvc_pkg::CHAN_W-1:0]  p_o,
  output logic [hsvc_pkg::CHAN_W-1:0]  q_o,
  output logic [hsvc_pkg::CHAN_W-1:0]  t_o
);
  import hsvc_pkg::*;

  hsvc_tag_t         tag3_r;
  logic [PROD_W-1:0] p_prod_r;
  logic [PROD_W-1:0] q_prod_r;
  logic [PROD_W-1:0] t_prod_r;
  hsvc_tag_t         tag4_r;
  logic [CHAN_W-1:0] p4_r;
  logic [CHAN_W-1:0] q4_r;
  logic [CHAN_W-1:0] t4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag3_r.valid <= 1'b0;
      tag4_r.valid <= 1'b0;
    end else begin
      tag3_r.valid <= tag_i.valid;
      tag4_r.valid <= tag3_r.valid;
    end
    tag3_r.sector <= tag_i.sector;
    p_prod_r      <= {{CHAN_W{1'b0}}, bri_i} * {{CHAN_W{1'b0}}, UNIT_ONE - sat_i};
    q_prod_r      <= {{CHAN_W{1'b0}}, bri_i} * {{CHAN_W{1'b0}}, UNIT_ONE - fs_i};
    t_prod_r      <= {{CHAN_W{1'b0}}, bri_i} * {{CHAN_W{1'b0}}, UNIT_ONE - gs_i};
    tag4_r.sector <= tag3_r.sector;
    p4_r          <= unit_div(p_prod_r);
    q4_r          <= unit_div(q_prod_r);
    t4_r          <= unit_div(t_prod_r);
  end

  assign tag_o = tag4_r;
  assign p_o   = p4_r;
  assign q_o   = q4_r;
  assign t_o   = t4_r;

`ifndef SYNTHESIS
  a_p_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tag4_r.valid |-> (p4_r <= q4_r || p4_r <= t4_r || p4_r == p4_r) && (t4_r >= p4_r))
    else $error("t fell below p");
`endif

endmodule

FILE: hw/rtl/hsv_to_rgb_converter_top.sv
// Top level of the HSV to RGB converter: configuration registers, pipeline
// and sector selection into the output word. Depends on hsvc_pkg, hsvc_frac, hsvc_scale.
//
// One hue word is accepted in every clock cycle in which start is high; busy is
// low whenever the block is out of reset. Each word yields one RGB word, shown for
// one cycle with out_valid, after passing through the five-stage pipeline (sector
// split, fraction products, value products, division by full scale, channel
// selection). Saturation and brightness may only be written while no word is in
// flight. The receiver cannot stall the output.
module hsv_to_rgb_converter_top #(
  parameter int unsigned COLOR_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [hsvc_pkg::CHAN_W-1:0]     in_hue,
  input  logic                            cfg_we,
  input  logic [hsvc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hsvc_pkg::CHAN_W-1:0]     cfg_wdata,
  output logic                            out_valid,
  output logic [hsvc_pkg::CHAN_W-1:0]     out_red,
  output logic [hsvc_pkg::CHAN_W-1:0]     out_green,
  output logic [hsvc_pkg::CHAN_W-1:0]     out_blue
);
  import hsvc_pkg::*;

  localparam int unsigned OUT_SHIFT = CHAN_W - COLOR_BITS;

  logic              in_fire;
  logic [CHAN_W-1:0] sat_r;
  logic [CHAN_W-1:0] bri_r;
  hsvc_tag_t         frac_tag;
  logic [CHAN_W-1:0] fs;
  logic [CHAN_W-1:0] gs;
  hsvc_tag_t         scale_tag;
  logic [CHAN_W-1:0] p_val;
  logic [CHAN_W-1:0] q_val;
  logic [CHAN_W-1:0] t_val;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;
  logic              out_valid_r;
  logic [CHAN_W-1:0] red_r;
  logic [CHAN_W-1:0] green_r;
  logic [CHAN_W-1:0] blue_r;

  assign busy    = ~rst_n;
  assign in_fire = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_r <= SATURATION_RESET;
      bri_r <= BRIGHTNESS_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_SATURATION) begin
        sat_r <= cfg_wdata;
      end
      if (cfg_index == REG_BRIGHTNESS) begin
        bri_r <= cfg_wdata;
      end
    end
  end

  hsvc_frac u_frac (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_fire),
    .hue_i    (in_hue),
    .sat_i    (sat_r),
    .tag_o    (frac_tag),
    .fs_o     (fs),
    .gs_o     (gs)
  );

  hsvc_scale u_scale (
    .clk   (clk),
    .rst_n (rst_n),
    .tag_i (frac_tag),
    .fs_i  (fs),
    .gs_i  (gs),
    .sat_i (sat_r),
    .bri_i (bri_r),
    .tag_o (scale_tag),
    .p_o   (p_val),
    .q_o   (q_val),
    .t_o   (t_val)
  );

  always_comb begin
    unique case (scale_tag.sector)
      SECT_RED_YELLOW: begin
        red = bri_r; green = t_val; blue = p_val;
      end
      SECT_YELLOW_GREEN: begin
        red = q_val; green = bri_r; blue = p_val;
      end
      SECT_GREEN_CYAN: begin
        red = p_val; green = bri_r; blue = t_val;
      end
      SECT_CYAN_BLUE: begin
        red = p_val; green = q_val; blue = bri_r;
      end
      SECT_BLUE_MAGENTA: begin
        red = t_val; green = p_val; blue = bri_r;
      end
      default: begin
        red = bri_r; green = p_val; blue = q_val;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= scale_tag.valid;
    end
    red_r   <= red >> OUT_SHIFT;
    green_r <= green >> OUT_SHIFT;
    blue_r  <= blue >> OUT_SHIFT;
  end

  assign out_valid = out_valid_r;
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

`ifndef SYNTHESIS
  a_word_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> ##5 out_valid)
    else $error("accepted word did not come out after five cycles");
  a_word_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_fire, 5))
    else $error("output word without a matching input word");
  a_ready: assert property (@(posedge clk)
    rst_n |-> !busy)
    else $error("busy raised out of reset");
`endif

endmodule
